// ===== hdl/ntew_pkg.sv =====
package ntew_pkg;

    // Input field width and digit grouping
    localparam int VALUE_W            = 40;
    localparam int CODE_W             = 5;
    localparam int GROUP_BITS         = 12;
    localparam int NTEW_DIGIT_GROUPS  = 4;

    // Word codes
    localparam logic [CODE_W-1:0] CODE_ONE     = 5'd0;
    localparam logic [CODE_W-1:0] CODE_TEN     = 5'd9;
    localparam logic [CODE_W-1:0] CODE_TWENTY  = 5'd19;
    localparam logic [CODE_W-1:0] CODE_HUNDRED = 5'd27;

    // Top level control
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    // Word slot within one group of three digits
    typedef enum logic [2:0] {
        SL_HUND,
        SL_HWORD,
        SL_TENS,
        SL_UNITS,
        SL_SCALE
    } slot_t;

    // Converter status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } conv_status_t;

    // Double dabble correction of one BCD digit
    function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
        bcd_adjust = (d >= 4'd5) ? d + 4'd3 : d;
    endfunction

endpackage

// ===== hdl/ntew_bcd.sv =====
module ntew_bcd
    import ntew_pkg::*;
#(
    parameter int DIGIT_GROUPS = NTEW_DIGIT_GROUPS
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  logic [VALUE_W-1:0]                 value,
    output logic [DIGIT_GROUPS*GROUP_BITS-1:0] bcd,
    output conv_status_t                       status
);

    localparam int DIGITS = DIGIT_GROUPS * 3;
    localparam int BCD_W  = DIGITS * 4;
    localparam int CNT_W  = $clog2(VALUE_W + 1);

    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [BCD_W-1:0]   bcd_adj;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;

    // Add-3 correction on every digit; digits above the top group drop out
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            bcd_adj[i*4 +: 4] = bcd_adjust(bcd_reg[i*4 +: 4]);
        end
    end

    // One binary bit shifted into the BCD register per cycle
    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (load)
        begin
            bin_next = value;
            bcd_next = '0;
            cnt_next = CNT_W'(VALUE_W);
        end
        else if (cnt_reg != '0)
        begin
            bin_next  = {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_next  = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign bcd         = bcd_reg;
    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;

endmodule

// ===== hdl/number_to_english_words_core.sv =====
// Flow: request accepted -> bit-serial binary to BCD conversion, a hand-over of the
// result into the group register, then one word slot per cycle while the output is
// not stalled, five slots per group; a zero group is passed over without stepping
// through its slots. No new request is taken until the sequencer has left its last group.
// Reset: rst_n asynchronous, active low; clears control state and output valid.
module number_to_english_words_core
    import ntew_pkg::*;
#(
    parameter int DIGIT_GROUPS = NTEW_DIGIT_GROUPS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [VALUE_W-1:0] value,
    output logic               word_valid,
    input  logic               word_stall,
    output logic [CODE_W-1:0]  word_code,
    output logic               is_last
);

    localparam int BCD_W = DIGIT_GROUPS * GROUP_BITS;
    localparam int POS_W = (DIGIT_GROUPS > 1) ? $clog2(DIGIT_GROUPS) : 1;

    state_t             state_reg, state_next;
    slot_t              slot_reg, slot_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [BCD_W-1:0]   grp_reg, grp_next;
    logic               word_valid_reg, word_valid_next;
    logic [CODE_W-1:0]  word_code_reg, word_code_next;
    logic               is_last_reg, is_last_next;

    logic [BCD_W-1:0]   conv_bcd;
    conv_status_t       conv_status;
    logic               req_accept;

    logic [BCD_W-1:0]   grp_shift;
    logic [3:0]         dig_h, dig_t, dig_u;
    logic               grp_nz, rest_zero;
    logic               has_h, has_t, has_u, has_s;
    logic               slot_present, slot_later;
    logic [CODE_W-1:0]  slot_code;
    logic               out_free, group_done;

    assign req_accept = req_valid && !req_stall;

    ntew_bcd #(
        .DIGIT_GROUPS (DIGIT_GROUPS)
    ) u_bcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (req_accept),
        .value  (value),
        .bcd    (conv_bcd),
        .status (conv_status)
    );

    // Top group digits and what follows them
    assign grp_shift = grp_reg << GROUP_BITS;
    assign dig_h     = grp_reg[BCD_W-1 -: 4];
    assign dig_t     = grp_reg[BCD_W-5 -: 4];
    assign dig_u     = grp_reg[BCD_W-9 -: 4];
    assign grp_nz    = (grp_reg[BCD_W-1 -: GROUP_BITS] != '0);
    assign rest_zero = (grp_shift == '0);
    assign has_h     = (dig_h != 4'd0);
    assign has_t     = (dig_t != 4'd0);
    assign has_u     = (dig_t != 4'd1) && (dig_u != 4'd0);
    assign has_s     = (pos_reg != '0);
    assign out_free  = !word_valid_reg || !word_stall;

    // Word for the current slot, and whether any word follows it in the group
    always_comb
    begin
        slot_present = 1'b0;
        slot_later   = 1'b0;
        slot_code    = CODE_HUNDRED;
        unique case (slot_reg)
            SL_HUND:
            begin
                slot_present = has_h;
                slot_later   = 1'b1;
                slot_code    = CODE_ONE + {1'b0, dig_h} - 5'd1;
            end
            SL_HWORD:
            begin
                slot_present = has_h;
                slot_later   = has_t || has_u || has_s;
                slot_code    = CODE_HUNDRED;
            end
            SL_TENS:
            begin
                slot_present = has_t;
                slot_later   = has_u || has_s;
                slot_code    = (dig_t == 4'd1) ? CODE_TEN + {1'b0, dig_u}
                                               : CODE_TWENTY + {1'b0, dig_t} - 5'd2;
            end
            SL_UNITS:
            begin
                slot_present = has_u;
                slot_later   = has_s;
                slot_code    = CODE_ONE + {1'b0, dig_u} - 5'd1;
            end
            SL_SCALE:
            begin
                slot_present = has_s;
                slot_later   = 1'b0;
                slot_code    = CODE_HUNDRED + CODE_W'(pos_reg);
            end
            default:
            begin
                slot_present = 1'b0;
                slot_later   = 1'b0;
                slot_code    = CODE_HUNDRED;
            end
        endcase
    end

    // Group finished: zero group, or last slot passed
    assign group_done = (state_reg == ST_EMIT) &&
                        (!grp_nz ||
                         ((slot_reg == SL_SCALE) && (!slot_present || out_free)));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_status.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (group_done && (pos_reg == '0))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer datapath and output register
    always_comb
    begin
        slot_next       = slot_reg;
        pos_next        = pos_reg;
        grp_next        = grp_reg;
        word_valid_next = word_valid_reg && word_stall;
        word_code_next  = word_code_reg;
        is_last_next    = is_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                slot_next = SL_HUND;
            end
            ST_CONV:
            begin
                if (conv_status.done)
                begin
                    grp_next  = conv_bcd;
                    pos_next  = POS_W'(DIGIT_GROUPS - 1);
                    slot_next = SL_HUND;
                end
            end
            ST_EMIT:
            begin
                if (grp_nz && slot_present && out_free)
                begin
                    word_valid_next = 1'b1;
                    word_code_next  = slot_code;
                    is_last_next    = !slot_later && rest_zero;
                end
                if (group_done)
                begin
                    slot_next = SL_HUND;
                    grp_next  = grp_shift;
                    if (pos_reg != '0)
                    begin
                        pos_next = pos_reg - 1'b1;
                    end
                end
                else if (!slot_present || out_free)
                begin
                    slot_next = slot_t'(slot_reg + 3'd1);
                end
            end
            default:
            begin
                slot_next = SL_HUND;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_reg       <= SL_HUND;
            pos_reg        <= '0;
            word_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_reg       <= slot_next;
            pos_reg        <= pos_next;
            word_valid_reg <= word_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg       <= grp_next;
        word_code_reg <= word_code_next;
        is_last_reg   <= is_last_next;
    end

    assign req_stall  = (state_reg != ST_IDLE);
    assign word_valid = word_valid_reg;
    assign word_code  = word_code_reg;
    assign is_last    = is_last_reg;

    // Converter runs only while the sequencer waits for it
    a_conv_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !conv_status.busy)
        else $error("converter busy while idle");

    // Conversion result arrives only in the conversion state
    a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        conv_status.done |-> (state_reg == ST_CONV))
        else $error("conversion done outside conversion state");

    // An accepted request always starts a conversion
    a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |=> (state_reg == ST_CONV) && conv_status.busy)
        else $error("request accepted without conversion");

    // Nothing follows the final word of a run right away
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (word_valid && !word_stall && is_last) |=> !word_valid)
        else $error("word emitted right after final word");

endmodule
